### rtl/core/dsa_pkg.sv
// Shared types and constants for the descriptor slot allocator.
// Used by dsa_ctrl, dsa_dp and descriptor_slot_allocator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int ROW_W       = 5;
  localparam int MAX_ROWS    = 32;
  localparam int SLOT_W      = 10;
  localparam int CNT_W       = 11;
  localparam int STRIDE_W    = 16;
  localparam int ADDR_W      = 64;
  localparam int PROD_W      = STRIDE_W + SLOT_W;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 168;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_RTV_CPU_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DSV_CPU_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRV_CPU_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRV_GPU_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RTV_STRIDE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DSV_STRIDE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SRV_STRIDE   = 3'd6;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_PEEK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    POOL_RTV  = 2'd0,
    POOL_DSV  = 2'd1,
    POOL_SRV  = 2'd2,
    POOL_NONE = 2'd3
  } pool_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_RANGE = 3'd2,
    ST_FREE  = 3'd3,
    ST_BUSY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_ADDR = 3'd1,
    S_EVAL = 3'd2,
    S_MUL  = 3'd3,
    S_DONE = 3'd4
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic eval;
    logic mul;
    logic load_out;
  } dp_cmd_t;

  // lowest set bit of a 32-bit word
  function automatic logic [BIT_W-1:0] first_one32(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### rtl/core/dsa_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/dsa_ctrl.sv
// Sequencing state machine for the descriptor slot allocator.
// Depends on dsa_pkg; drives dsa_dp through a dp_cmd_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module dsa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output dsa_pkg::dp_cmd_t      dp_cmd
);

  dsa_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    state_nxt = state_r;
    in_tready = 1'b0;
    dp_cmd    = '0;
    case (state_r)
      dsa_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dp_cmd.load_in = 1'b1;
          state_nxt      = dsa_pkg::S_ADDR;
        end
      end
      dsa_pkg::S_ADDR: begin
        dp_cmd.rd_en = 1'b1;
        state_nxt    = dsa_pkg::S_EVAL;
      end
      dsa_pkg::S_EVAL: begin
        dp_cmd.eval = 1'b1;
        state_nxt   = dsa_pkg::S_MUL;
      end
      dsa_pkg::S_MUL: begin
        dp_cmd.mul = 1'b1;
        state_nxt  = dsa_pkg::S_DONE;
      end
      dsa_pkg::S_DONE: begin
        if (out_free) begin
          dp_cmd.load_out = 1'b1;
          in_tready       = 1'b1;
          if (in_tvalid) begin
            dp_cmd.load_in = 1'b1;
            state_nxt      = dsa_pkg::S_ADDR;
          end else begin
            state_nxt = dsa_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dsa_pkg::S_IDLE;
      end
    endcase
    if (dp_cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == dsa_pkg::S_ADDR))
    else $error("accepted word did not start a lookup");

  assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending word");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == dsa_pkg::S_DONE))
    else $error("result raised outside the done step");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsa_pkg::S_EVAL) |-> ($past(state_r) == dsa_pkg::S_ADDR))
    else $error("bitmap update without a preceding read");

endmodule

`default_nettype wire

### rtl/core/dsa_dp.sv
// Datapath: config registers, bitmap RAM with row valid/full flags, free counters,
// address multiply and result register. Depends on dsa_pkg and dsa_ram.
`timescale 1ns / 1ps
`default_nettype none

module dsa_dp #(
  parameter int RTV_SLOTS = 16,
  parameter int DSV_SLOTS = 8,
  parameter int SRV_SLOTS = 512
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire dsa_pkg::dp_cmd_t                     dp_cmd,
  input  wire logic [dsa_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [dsa_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire logic [dsa_pkg::ADDR_W-1:0]           cfg_wdata,
  output logic      [dsa_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int RTV_ROWS = (RTV_SLOTS + dsa_pkg::WORD_W - 1) / dsa_pkg::WORD_W;
  localparam int DSV_ROWS = (DSV_SLOTS + dsa_pkg::WORD_W - 1) / dsa_pkg::WORD_W;
  localparam int SRV_ROWS = (SRV_SLOTS + dsa_pkg::WORD_W - 1) / dsa_pkg::WORD_W;
  localparam int DSV_OFF  = RTV_ROWS;
  localparam int SRV_OFF  = RTV_ROWS + DSV_ROWS;
  localparam int ROWS     = RTV_ROWS + DSV_ROWS + SRV_ROWS;
  localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCW      = dsa_pkg::ROW_W + 1;

  // configuration
  logic [dsa_pkg::ADDR_W-1:0]   rtv_cpu_base_r, dsv_cpu_base_r, srv_cpu_base_r, srv_gpu_base_r;
  logic [dsa_pkg::STRIDE_W-1:0] rtv_stride_r, dsv_stride_r, srv_stride_r;

  // request
  dsa_pkg::cmd_t             cmd_r;
  dsa_pkg::pool_t            pool_r;
  logic [dsa_pkg::SLOT_W-1:0] req_r;

  // bitmap bookkeeping
  logic [ROWS-1:0]           row_valid_r, row_full_r;
  logic [dsa_pkg::CNT_W-1:0] rtv_free_r, dsv_free_r, srv_free_r;

  // lookup stage
  logic [dsa_pkg::CNT_W-1:0]  size_c;
  logic [RCW-1:0]             rows_c;
  logic [RAW-1:0]             off_c;
  logic [dsa_pkg::WORD_W-1:0] nf_c;
  logic [dsa_pkg::ROW_W-1:0]  row_c;
  logic [RAW-1:0]             raddr_c;
  logic                       bad_c;
  dsa_pkg::status_t           err_c;
  logic                       rvalid_c;

  logic [dsa_pkg::ROW_W-1:0]  row_r;
  logic [RAW-1:0]             rowidx_r;
  dsa_pkg::status_t           err_r;
  logic                       rvalid_r;

  // evaluate stage
  logic [dsa_pkg::WORD_W-1:0] ram_q;
  logic [dsa_pkg::WORD_W-1:0] word_c, pad_c, mask_c, new_word_c;
  logic [dsa_pkg::BIT_W-1:0]  bit_c;
  logic                       cur_c, set_c, clr_c, ok_c, inuse_c, we_c;
  dsa_pkg::status_t           status_c;

  dsa_pkg::status_t           status_r;
  logic [dsa_pkg::SLOT_W-1:0] slot_r;
  logic                       ok_r, inuse_r;

  // multiply stage
  logic [dsa_pkg::STRIDE_W-1:0] stride_c;
  logic [dsa_pkg::ADDR_W-1:0]   cpu_base_c;
  logic [dsa_pkg::CNT_W-1:0]    free_c;
  logic [dsa_pkg::PROD_W-1:0]   cpu_prod_r, gpu_prod_r;
  logic [dsa_pkg::ADDR_W-1:0]   cpu_base_q_r;
  logic                         gpu_en_r;
  logic [dsa_pkg::CNT_W-1:0]    free_q_r, used_q_r;

  // result
  logic [dsa_pkg::ADDR_W-1:0]   cpu_addr_c, gpu_addr_c;
  logic [dsa_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtv_cpu_base_r <= '0;
      dsv_cpu_base_r <= '0;
      srv_cpu_base_r <= '0;
      srv_gpu_base_r <= '0;
      rtv_stride_r   <= dsa_pkg::STRIDE_RESET;
      dsv_stride_r   <= dsa_pkg::STRIDE_RESET;
      srv_stride_r   <= dsa_pkg::STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        dsa_pkg::CFG_RTV_CPU_BASE: rtv_cpu_base_r <= cfg_wdata;
        dsa_pkg::CFG_DSV_CPU_BASE: dsv_cpu_base_r <= cfg_wdata;
        dsa_pkg::CFG_SRV_CPU_BASE: srv_cpu_base_r <= cfg_wdata;
        dsa_pkg::CFG_SRV_GPU_BASE: srv_gpu_base_r <= cfg_wdata;
        dsa_pkg::CFG_RTV_STRIDE:   rtv_stride_r   <= cfg_wdata[dsa_pkg::STRIDE_W-1:0];
        dsa_pkg::CFG_DSV_STRIDE:   dsv_stride_r   <= cfg_wdata[dsa_pkg::STRIDE_W-1:0];
        dsa_pkg::CFG_SRV_STRIDE:   srv_stride_r   <= cfg_wdata[dsa_pkg::STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pool selection
  always_comb begin
    case (pool_r)
      dsa_pkg::POOL_RTV: begin
        size_c     = dsa_pkg::CNT_W'(RTV_SLOTS);
        rows_c     = RCW'(RTV_ROWS);
        off_c      = '0;
        stride_c   = rtv_stride_r;
        cpu_base_c = rtv_cpu_base_r;
        free_c     = rtv_free_r;
      end
      dsa_pkg::POOL_DSV: begin
        size_c     = dsa_pkg::CNT_W'(DSV_SLOTS);
        rows_c     = RCW'(DSV_ROWS);
        off_c      = RAW'(DSV_OFF);
        stride_c   = dsv_stride_r;
        cpu_base_c = dsv_cpu_base_r;
        free_c     = dsv_free_r;
      end
      dsa_pkg::POOL_SRV: begin
        size_c     = dsa_pkg::CNT_W'(SRV_SLOTS);
        rows_c     = RCW'(SRV_ROWS);
        off_c      = RAW'(SRV_OFF);
        stride_c   = srv_stride_r;
        cpu_base_c = srv_cpu_base_r;
        free_c     = srv_free_r;
      end
      default: begin
        size_c     = '0;
        rows_c     = '0;
        off_c      = '0;
        stride_c   = '0;
        cpu_base_c = '0;
        free_c     = '0;
      end
    endcase
  end

  // lookup: first row with a free slot for alloc, else the requested row; range check
  always_comb begin
    for (int r = 0; r < dsa_pkg::MAX_ROWS; r++) begin
      nf_c[r] = (RCW'(r) < rows_c) && !row_full_r[off_c + RAW'(r)];
    end
    row_c   = (cmd_r == dsa_pkg::CMD_ALLOC) ? dsa_pkg::first_one32(nf_c)
                                            : req_r[dsa_pkg::SLOT_W-1:dsa_pkg::BIT_W];
    raddr_c = off_c + RAW'(row_c);
    bad_c   = (pool_r == dsa_pkg::POOL_NONE) ||
              ((cmd_r != dsa_pkg::CMD_ALLOC) && ({1'b0, req_r} >= size_c));
    if (bad_c) begin
      err_c = dsa_pkg::ST_RANGE;
    end else if ((cmd_r == dsa_pkg::CMD_ALLOC) && !(|nf_c)) begin
      err_c = dsa_pkg::ST_FULL;
    end else begin
      err_c = dsa_pkg::ST_OK;
    end
    rvalid_c = !bad_c && row_valid_r[raddr_c];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      cmd_r  <= dsa_pkg::cmd_t'(in_tdata[1:0]);
      pool_r <= dsa_pkg::pool_t'(in_tdata[3:2]);
      req_r  <= in_tdata[13:4];
    end
    if (dp_cmd.rd_en) begin
      row_r    <= row_c;
      rowidx_r <= raddr_c;
      err_r    <= err_c;
      rvalid_r <= rvalid_c;
    end
  end

  dsa_ram #(
    .WIDTH(dsa_pkg::WORD_W),
    .DEPTH(ROWS)
  ) u_bitmap (
    .clk  (clk),
    .we   (we_c),
    .waddr(rowidx_r),
    .wdata(new_word_c),
    .re   (dp_cmd.rd_en),
    .raddr(raddr_c),
    .rdata(ram_q)
  );

  // evaluate: pick one bit of the row; alloc, release and reserve may modify it
  always_comb begin
    word_c = rvalid_r ? ram_q : '0;
    for (int b = 0; b < dsa_pkg::WORD_W; b++) begin
      pad_c[b] = {1'b0, row_r, dsa_pkg::BIT_W'(b)} >= size_c;
    end
    bit_c   = (cmd_r == dsa_pkg::CMD_ALLOC) ? dsa_pkg::first_one32(~(word_c | pad_c))
                                            : req_r[dsa_pkg::BIT_W-1:0];
    mask_c  = dsa_pkg::WORD_W'(1) << bit_c;
    cur_c   = word_c[bit_c];
    set_c   = 1'b0;
    clr_c   = 1'b0;
    ok_c    = 1'b0;
    inuse_c = 1'b0;
    status_c = err_r;
    if (err_r == dsa_pkg::ST_OK) begin
      case (cmd_r)
        dsa_pkg::CMD_ALLOC: begin
          set_c   = 1'b1;
          ok_c    = 1'b1;
          inuse_c = 1'b1;
        end
        dsa_pkg::CMD_RELEASE: begin
          if (!cur_c) begin
            status_c = dsa_pkg::ST_FREE;
          end else begin
            clr_c = 1'b1;
            ok_c  = 1'b1;
          end
        end
        dsa_pkg::CMD_RESERVE: begin
          inuse_c = 1'b1;
          if (cur_c) begin
            status_c = dsa_pkg::ST_BUSY;
          end else begin
            set_c = 1'b1;
            ok_c  = 1'b1;
          end
        end
        dsa_pkg::CMD_PEEK: begin
          ok_c    = 1'b1;
          inuse_c = cur_c;
        end
        default: begin
        end
      endcase
    end
    new_word_c = set_c ? (word_c | mask_c) : (word_c & ~mask_c);
    we_c       = dp_cmd.eval && (set_c || clr_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      row_full_r  <= '0;
      rtv_free_r  <= dsa_pkg::CNT_W'(RTV_SLOTS);
      dsv_free_r  <= dsa_pkg::CNT_W'(DSV_SLOTS);
      srv_free_r  <= dsa_pkg::CNT_W'(SRV_SLOTS);
    end else if (we_c) begin
      row_valid_r[rowidx_r] <= 1'b1;
      row_full_r[rowidx_r]  <= &(new_word_c | pad_c);
      case (pool_r)
        dsa_pkg::POOL_RTV: rtv_free_r <= set_c ? rtv_free_r - 1'b1 : rtv_free_r + 1'b1;
        dsa_pkg::POOL_DSV: dsv_free_r <= set_c ? dsv_free_r - 1'b1 : dsv_free_r + 1'b1;
        dsa_pkg::POOL_SRV: srv_free_r <= set_c ? srv_free_r - 1'b1 : srv_free_r + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.eval) begin
      status_r <= status_c;
      slot_r   <= ok_c ? {row_r, bit_c} : '0;
      ok_r     <= ok_c;
      inuse_r  <= inuse_c;
    end
    if (dp_cmd.mul) begin
      cpu_prod_r   <= {{dsa_pkg::SLOT_W{1'b0}}, stride_c} *
                      {{dsa_pkg::STRIDE_W{1'b0}}, slot_r};
      gpu_prod_r   <= {{dsa_pkg::SLOT_W{1'b0}}, srv_stride_r} *
                      {{dsa_pkg::STRIDE_W{1'b0}}, slot_r};
      cpu_base_q_r <= cpu_base_c;
      gpu_en_r     <= ok_r && (pool_r == dsa_pkg::POOL_SRV);
      free_q_r     <= free_c;
      used_q_r     <= size_c - free_c;
    end
  end

  // result: base add and pack
  assign cpu_addr_c = ok_r ? cpu_base_q_r + dsa_pkg::ADDR_W'(cpu_prod_r) : '0;
  assign gpu_addr_c = gpu_en_r ? srv_gpu_base_r + dsa_pkg::ADDR_W'(gpu_prod_r) : '0;

  always_ff @(posedge clk) begin
    if (dp_cmd.load_out) begin
      out_tdata_r <= {4'b0, used_q_r, free_q_r, inuse_r, gpu_addr_c, cpu_addr_c,
                      slot_r, status_r};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

`default_nettype wire

### rtl/core/descriptor_slot_allocator.sv
// An accepted input word steps through the address, evaluate, multiply and done states;
// out_tvalid rises once the result is loaded, which waits while a result is pending.
// Words are taken one at a time: row lookup, bitmap RAM read, bit update, multiply, base add.
// Reset: synchronous active-low; all slots free via per-row valid flags (no clearing
// pass), bases 0, strides 32. Depends on dsa_pkg, dsa_ctrl, dsa_dp, dsa_ram.
`timescale 1ns / 1ps
`default_nettype none

module descriptor_slot_allocator #(
  parameter int RTV_SLOTS = 16,
  parameter int DSV_SLOTS = 8,
  parameter int SRV_SLOTS = 512
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // cmd[1:0], pool_select[3:2], req_slot[13:4], zero[15:14]
  input  wire logic [dsa_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // status[2:0], granted_slot[12:3], cpu_address[76:13], gpu_address[140:77],
  // slot_in_use[141], free_count[152:142], used_count[163:153], zero[167:164]
  output logic      [dsa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [dsa_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [dsa_pkg::ADDR_W-1:0]         cfg_wdata
);

  dsa_pkg::dp_cmd_t dp_cmd;

  dsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .dp_cmd    (dp_cmd)
  );

  dsa_dp #(
    .RTV_SLOTS(RTV_SLOTS),
    .DSV_SLOTS(DSV_SLOTS),
    .SRV_SLOTS(SRV_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_cmd   (dp_cmd),
    .in_tdata (in_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .out_tdata(out_tdata)
  );

endmodule

`default_nettype wire
